// ===== src/mmcp_pkg.sv =====
// shared constants and types for the min-max contiguous partition block
package mmcp_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 20;
    localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W      = VALUE_BITS + ADDR_W;
    localparam int IN_W       = 20;
    localparam int LIMIT_W    = 11;
    localparam int OUT_W      = 30;
    localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [1:0] {
        SRCH_IDLE,
        SRCH_CHECK,
        SRCH_WALK
    } srch_state_t;

    typedef struct packed {
        logic             go;
        logic [SUM_W-1:0] lo;
        logic [SUM_W-1:0] hi;
        logic [CNT_W-1:0] count;
    } srch_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] result;
    } srch_rsp_t;

endpackage

// ===== src/mmcp_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module mmcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mmcp_search.sv =====
// binary search over the bound, each probe a greedy walk through the element ram
module mmcp_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mmcp_pkg::srch_req_t            req,
    input  logic [mmcp_pkg::LIMIT_W-1:0]   part_limit,
    output logic                           rd_en,
    output logic [mmcp_pkg::ADDR_W-1:0]    rd_addr,
    input  logic [mmcp_pkg::VALUE_BITS-1:0] rd_data,
    output mmcp_pkg::srch_rsp_t            rsp
);

    localparam int SW = mmcp_pkg::SUM_W;
    localparam int CW = mmcp_pkg::CNT_W;

    mmcp_pkg::srch_state_t state_reg, state_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [SW-1:0] hi_reg, hi_next;
    logic [SW-1:0] mid_reg, mid_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] parts_reg, parts_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pending_reg, pending_next;

    logic [SW:0]   mid_wide;
    logic [SW:0]   sum_ext;
    logic          issue;
    logic          fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mmcp_pkg::SRCH_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
        parts_reg <= parts_next;
        idx_reg   <= idx_next;
    end

    assign mid_wide = ((SW+1)'(lo_reg) + (SW+1)'(hi_reg)) >> 1;
    assign sum_ext  = (SW+1)'(sum_reg) + (SW+1)'(rd_data);
    assign issue    = (state_reg == mmcp_pkg::SRCH_WALK) && (idx_reg < count_reg);
    assign fits     = mmcp_pkg::CMP_W'(parts_reg) <= mmcp_pkg::CMP_W'(part_limit);
    assign rd_en    = issue;
    assign rd_addr  = idx_reg[mmcp_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        parts_next   = parts_reg;
        idx_next     = idx_reg;
        pending_next = 1'b0;
        rsp.busy     = (state_reg != mmcp_pkg::SRCH_IDLE);
        rsp.done     = 1'b0;
        rsp.result   = lo_reg;

        unique case (state_reg)
            mmcp_pkg::SRCH_IDLE:
            begin
                if (req.go)
                begin
                    lo_next    = req.lo;
                    hi_next    = req.hi;
                    count_next = req.count;
                    state_next = mmcp_pkg::SRCH_CHECK;
                end
            end
            mmcp_pkg::SRCH_CHECK:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_wide[SW-1:0];
                    sum_next   = '0;
                    parts_next = CW'(1);
                    idx_next   = '0;
                    state_next = mmcp_pkg::SRCH_WALK;
                end
                else
                begin
                    rsp.done   = 1'b1;
                    state_next = mmcp_pkg::SRCH_IDLE;
                end
            end
            mmcp_pkg::SRCH_WALK:
            begin
                // ram read data is registered: each element is consumed in the cycle after its read is issued
                if (issue)
                begin
                    idx_next     = idx_reg + CW'(1);
                    pending_next = 1'b1;
                end
                if (pending_reg)
                begin
                    if (sum_ext > (SW+1)'(mid_reg))
                    begin
                        parts_next = parts_reg + CW'(1);
                        sum_next   = SW'(rd_data);
                    end
                    else
                    begin
                        sum_next = sum_ext[SW-1:0];
                    end
                end
                else if (!issue)
                begin
                    if (fits)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + SW'(1);
                    end
                    state_next = mmcp_pkg::SRCH_CHECK;
                end
            end
            default:
            begin
                state_next = mmcp_pkg::SRCH_IDLE;
            end
        endcase
    end

    a_busy_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp.busy) |-> $past(rsp.done))
        else $error("search left busy without a result beat");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmcp_pkg::SRCH_WALK) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmcp_pkg::SRCH_WALK) |-> (mid_reg >= lo_reg && mid_reg < hi_reg))
        else $error("probe bound outside search window");

    a_part_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmcp_pkg::SRCH_WALK) |-> (sum_reg <= mid_reg))
        else $error("running part sum above probe bound");

endmodule

// ===== src/min_max_contiguous_partition_top.sv =====
// top level: element loading, part limit register and search launch
//
// Elements load one per cycle (start high while busy is low) into an element
// ram; the largest element and the running total are tracked on the fly. The
// beat with last set launches a binary search for the smallest bound whose
// greedy left-to-right cut needs at most part_limit parts, and busy stays high
// until the answer appears. Each probe walks the element ram one read per cycle,
// and the search runs about ceil(log2(total - largest + 1)) probes, with a check
// step before each probe to form the midpoint and one more to finish. The answer
// shows on largest_sum for exactly one cycle with done high; the receiver cannot
// stall it, and busy drops on the cycle after. Elements beyond the ram depth are
// dropped, though their last bit still ends the array.
module min_max_contiguous_partition_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mmcp_pkg::IN_W-1:0]        value,
    input  logic                             last,
    input  logic                             cfg_we,
    input  logic [mmcp_pkg::LIMIT_W-1:0]     cfg_data,
    output logic                             done,
    output logic [mmcp_pkg::OUT_W-1:0]       largest_sum
);

    localparam int SW = mmcp_pkg::SUM_W;
    localparam int CW = mmcp_pkg::CNT_W;
    localparam int VW = mmcp_pkg::VALUE_BITS;

    logic [CW-1:0]               count_reg, count_next;
    logic [VW-1:0]               max_reg, max_next;
    logic [SW-1:0]               total_reg, total_next;
    logic [mmcp_pkg::LIMIT_W-1:0] limit_reg;

    logic                        accept;
    logic                        store;
    logic [VW-1:0]               elem;
    logic [VW-1:0]               max_upd;
    logic [SW-1:0]               total_upd;

    logic                        rd_en;
    logic [mmcp_pkg::ADDR_W-1:0] rd_addr;
    logic [VW-1:0]               rd_data;

    mmcp_pkg::srch_req_t         req;
    mmcp_pkg::srch_rsp_t         rsp;

    assign accept = start && !busy;
    assign elem   = VW'(value);
    assign store  = accept && (count_reg < CW'(mmcp_pkg::MAX_ITEMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= '0;
            total_reg <= '0;
            limit_reg <= mmcp_pkg::LIMIT_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            total_reg <= total_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        max_upd   = max_reg;
        total_upd = total_reg;
        count_next = count_reg;
        if (store)
        begin
            max_upd    = (elem > max_reg) ? elem : max_reg;
            total_upd  = total_reg + SW'(elem);
            count_next = count_reg + CW'(1);
        end
        max_next   = max_upd;
        total_next = total_upd;

        req.go    = accept && last;
        req.lo    = SW'(max_upd);
        req.hi    = total_upd;
        req.count = count_next;

        // the array is handed off, clear for the next one
        if (accept && last)
        begin
            count_next = '0;
            max_next   = '0;
            total_next = '0;
        end
    end

    mmcp_ram #(
        .WIDTH (VW),
        .DEPTH (mmcp_pkg::MAX_ITEMS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[mmcp_pkg::ADDR_W-1:0]),
        .wdata (elem),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mmcp_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .part_limit (limit_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rsp        (rsp)
    );

    assign busy        = rsp.busy;
    assign done        = rsp.done;
    assign largest_sum = mmcp_pkg::OUT_W'(rsp.result);

endmodule
